// ===== hdl/scs1a_pkg.sv =====
package scs1a_pkg;

   localparam int unsigned CodeWidth = 7;
   localparam int unsigned CharWidth = 7;

   typedef logic [CodeWidth-1:0] code_type;
   typedef logic [CharWidth-1:0] char_type;

   localparam code_type ScShiftLeft  = 7'h2A;
   localparam code_type ScShiftRight = 7'h36;
   localparam code_type ScEnter      = 7'h1C;
   localparam code_type ScBackspace  = 7'h0E;
   localparam code_type ScTab        = 7'h0F;
   localparam code_type ScSpace      = 7'h39;

   localparam char_type ChNone      = 7'h00;
   localparam char_type ChLineFeed  = 7'h0A;
   localparam char_type ChBackspace = 7'h08;
   localparam char_type ChTab       = 7'h09;
   localparam char_type ChSpace     = 7'h20;

   typedef struct packed {
      char_type  char_code;
      logic      shift_on;
      logic      released;
      code_type  scan_code;
   } rsp_type;

   function automatic logic is_shift_key(input code_type code);
      return (code == ScShiftLeft) || (code == ScShiftRight);
   endfunction

   function automatic char_type char_lookup(input code_type code, input logic up);
      char_type ch;
      ch = ChNone;
      unique case (code)
         ScEnter:     ch = ChLineFeed;
         ScBackspace: ch = ChBackspace;
         ScTab:       ch = ChTab;
         ScSpace:     ch = ChSpace;
         7'h10:       ch = up ? 7'h51 : 7'h71;
         7'h11:       ch = up ? 7'h57 : 7'h77;
         7'h12:       ch = up ? 7'h45 : 7'h65;
         7'h13:       ch = up ? 7'h52 : 7'h72;
         7'h14:       ch = up ? 7'h54 : 7'h74;
         7'h15:       ch = up ? 7'h59 : 7'h79;
         7'h16:       ch = up ? 7'h55 : 7'h75;
         7'h17:       ch = up ? 7'h49 : 7'h69;
         7'h18:       ch = up ? 7'h4F : 7'h6F;
         7'h19:       ch = up ? 7'h50 : 7'h70;
         7'h1E:       ch = up ? 7'h41 : 7'h61;
         7'h1F:       ch = up ? 7'h53 : 7'h73;
         7'h20:       ch = up ? 7'h44 : 7'h64;
         7'h21:       ch = up ? 7'h46 : 7'h66;
         7'h22:       ch = up ? 7'h47 : 7'h67;
         7'h23:       ch = up ? 7'h48 : 7'h68;
         7'h24:       ch = up ? 7'h4A : 7'h6A;
         7'h25:       ch = up ? 7'h4B : 7'h6B;
         7'h26:       ch = up ? 7'h4C : 7'h6C;
         7'h2C:       ch = up ? 7'h5A : 7'h7A;
         7'h2D:       ch = up ? 7'h58 : 7'h78;
         7'h2E:       ch = up ? 7'h43 : 7'h63;
         7'h2F:       ch = up ? 7'h56 : 7'h76;
         7'h30:       ch = up ? 7'h42 : 7'h62;
         7'h31:       ch = up ? 7'h4E : 7'h6E;
         7'h32:       ch = up ? 7'h4D : 7'h6D;
         7'h02:       ch = up ? 7'h21 : 7'h31;
         7'h03:       ch = up ? 7'h40 : 7'h32;
         7'h04:       ch = up ? 7'h23 : 7'h33;
         7'h05:       ch = up ? 7'h24 : 7'h34;
         7'h06:       ch = up ? 7'h25 : 7'h35;
         7'h07:       ch = up ? 7'h5E : 7'h36;
         7'h08:       ch = up ? 7'h26 : 7'h37;
         7'h09:       ch = up ? 7'h2A : 7'h38;
         7'h0A:       ch = up ? 7'h28 : 7'h39;
         7'h0B:       ch = up ? 7'h29 : 7'h30;
         default:     ch = ChNone;
      endcase
      return ch;
   endfunction

endpackage

// ===== hdl/scancode_set1_to_ascii.sv =====
// Channel   Dir  Word bits  Contents
// req_      in   8          raw_code
// rsp_      out  16         scan_code, released, shift_on, char_code
//
// Two register stages: an input register and a result register.
// One word per cycle sustained while rsp_tready is held high; a word passes the input and result registers.
// Synchronous active-high reset clears both valid flags and the shift flag.
// The shift flag updates as a word moves from the input to the result register.
// A stall on rsp_ holds both stages; req_tready falls only when both are full.
module scancode_set1_to_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] raw_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [6:0] scan_code, [7] released, [8] shift_on,
                                    // [15:9] char_code
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [7:0]            s1_raw_ff;
   logic                  shift_ff, shift_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   scs1a_pkg::rsp_type    rsp_ff, rsp_in;
   scs1a_pkg::code_type   s1_code;
   logic                  s1_rel;
   logic                  adv_out;
   logic                  load_out;

   assign s1_code    = s1_raw_ff[6:0];
   assign s1_rel     = s1_raw_ff[7];
   assign adv_out    = !rsp_valid_ff || rsp_tready;
   assign load_out   = s1_valid_ff && adv_out;
   assign req_tready = !s1_valid_ff || adv_out;

   always_comb begin
      s1_valid_in  = req_tvalid || (s1_valid_ff && !adv_out);
      rsp_valid_in = s1_valid_ff || (rsp_valid_ff && !rsp_tready);
      shift_in     = shift_ff;
      if (load_out && scs1a_pkg::is_shift_key(s1_code)) begin
         shift_in = !s1_rel;
      end
      rsp_in.scan_code  = s1_code;
      rsp_in.released   = s1_rel;
      rsp_in.shift_on   = shift_in;
      rsp_in.char_code  = scs1a_pkg::char_lookup(s1_code, shift_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         shift_ff     <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (adv_out) begin
            rsp_valid_ff <= rsp_valid_in;
         end
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_raw_ff <= req_tdata;
      end
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   a_shift_reset: assert property (@(posedge clock) reset |=> !shift_ff)
      else $error("shift flag not cleared by reset");

   a_shift_out: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_ff.shift_on == shift_ff)
      else $error("result shift_on disagrees with kept shift flag");

   a_shift_release: assert property (@(posedge clock) disable iff (reset)
      load_out && s1_rel && scs1a_pkg::is_shift_key(s1_code) |=> !shift_ff)
      else $error("shift release did not clear shift flag");

   a_shift_nochar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && scs1a_pkg::is_shift_key(rsp_ff.scan_code)
      |-> rsp_ff.char_code == scs1a_pkg::ChNone)
      else $error("shift key produced a character");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled while a stage is free");

endmodule

// ===== dv/scancode_set1_to_ascii_check.sv =====
`timescale 1ns / 1ps

module scancode_set1_to_ascii_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] raw_code
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [6:0] scan_code, [7] released, [8] shift_on,
                                    // [15:9] char_code
   output int          pending,
   output int          errors
);

   scs1a_pkg::rsp_type decoded_q[$];
   logic    shift_latch = 1'b0;
   int      err_total   = 0;

   function automatic scs1a_pkg::char_type key_char(input scs1a_pkg::code_type code,
                                                    input logic up);
      string row_top;
      string row_mid;
      string row_bot;
      string row_num;
      string row_sym;
      byte   ch;
      row_top = "qwertyuiop";
      row_mid = "asdfghjkl";
      row_bot = "zxcvbnm";
      row_num = "1234567890";
      row_sym = "!@#$%^&*()";
      ch = 8'h00;
      if (code == scs1a_pkg::ScEnter) begin
         ch = 8'h0A;
      end else if (code == scs1a_pkg::ScBackspace) begin
         ch = 8'h08;
      end else if (code == scs1a_pkg::ScTab) begin
         ch = 8'h09;
      end else if (code == scs1a_pkg::ScSpace) begin
         ch = 8'h20;
      end else if (code >= 7'h10 && code <= 7'h19) begin
         ch = row_top[code - 7'h10];
      end else if (code >= 7'h1E && code <= 7'h26) begin
         ch = row_mid[code - 7'h1E];
      end else if (code >= 7'h2C && code <= 7'h32) begin
         ch = row_bot[code - 7'h2C];
      end else if (code >= 7'h02 && code <= 7'h0B) begin
         ch = up ? row_sym[code - 7'h02] : row_num[code - 7'h02];
      end
      if (up && ch >= "a" && ch <= "z") begin
         ch = ch - 8'h20;
      end
      return scs1a_pkg::char_type'(ch);
   endfunction

   always @(posedge clock) begin
      scs1a_pkg::rsp_type got;
      scs1a_pkg::rsp_type want;
      if (reset) begin
         decoded_q.delete();
         shift_latch = 1'b0;
         err_total   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = scs1a_pkg::rsp_type'(rsp_tdata);
            if (decoded_q.size() == 0) begin
               $display("%0t: rsp word %h with nothing expected", $time, rsp_tdata);
               err_total++;
            end else begin
               want = decoded_q.pop_front();
               if (got.scan_code !== want.scan_code) begin
                  $display("%0t: scan_code expected %h actual %h",
                           $time, want.scan_code, got.scan_code);
                  err_total++;
               end
               if (got.released !== want.released) begin
                  $display("%0t: released expected %b actual %b",
                           $time, want.released, got.released);
                  err_total++;
               end
               if (got.shift_on !== want.shift_on) begin
                  $display("%0t: shift_on expected %b actual %b",
                           $time, want.shift_on, got.shift_on);
                  err_total++;
               end
               if (got.char_code !== want.char_code) begin
                  $display("%0t: char_code expected %h actual %h",
                           $time, want.char_code, got.char_code);
                  err_total++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want.scan_code = req_tdata[6:0];
            want.released  = req_tdata[7];
            if (want.scan_code == scs1a_pkg::ScShiftLeft ||
                want.scan_code == scs1a_pkg::ScShiftRight) begin
               shift_latch = !want.released;
            end
            want.shift_on   = shift_latch;
            want.char_code  = key_char(want.scan_code, shift_latch);
            decoded_q.push_back(want);
         end
      end
      pending <= decoded_q.size();
      errors  <= err_total;
   end

endmodule

// ===== dv/scancode_set1_to_ascii_tb.sv =====
`timescale 1ns / 1ps

module scancode_set1_to_ascii_tb;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] raw_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [6:0] scan_code, [7] released, [8] shift_on,
                                     // [15:9] char_code
   int          pending;
   int          errors;
   int          sent  = 0;
   int          taken = 0;

   localparam logic [7:0] OpeningCodes [25] = '{
      8'h00, 8'h7F, 8'h80, 8'hFF,
      {1'b0, scs1a_pkg::ScEnter}, {1'b0, scs1a_pkg::ScBackspace},
      {1'b0, scs1a_pkg::ScTab}, {1'b0, scs1a_pkg::ScSpace},
      8'h10, 8'h32, 8'h02, 8'h0B,
      {1'b0, scs1a_pkg::ScShiftLeft}, 8'h10, 8'h0B, 8'h90,
      {1'b0, scs1a_pkg::ScShiftRight}, {1'b1, scs1a_pkg::ScShiftLeft}, 8'h1E, 8'h9E,
      8'hE0, 8'hE1, {1'b1, scs1a_pkg::ScShiftRight}, 8'h01, 8'h26
   };

   always #6 clock = ~clock;

   scancode_set1_to_ascii uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   scancode_set1_to_ascii_check check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .pending    (pending),
      .errors     (errors)
   );

   function automatic scs1a_pkg::code_type pick_shift();
      return $urandom_range(0, 1) ? scs1a_pkg::ScShiftLeft : scs1a_pkg::ScShiftRight;
   endfunction

   function automatic scs1a_pkg::code_type pick_key();
      case ($urandom_range(0, 5))
         0: return scs1a_pkg::code_type'($urandom_range(8'h02, 8'h0B));
         1: return scs1a_pkg::code_type'($urandom_range(8'h10, 8'h19));
         2: return scs1a_pkg::code_type'($urandom_range(8'h1E, 8'h26));
         3: return scs1a_pkg::code_type'($urandom_range(8'h2C, 8'h32));
         4: begin
            case ($urandom_range(0, 3))
               0: return scs1a_pkg::ScEnter;
               1: return scs1a_pkg::ScBackspace;
               2: return scs1a_pkg::ScTab;
               default: return scs1a_pkg::ScSpace;
            endcase
         end
         default: return scs1a_pkg::code_type'($urandom_range(0, 8'h7F));
      endcase
   endfunction

   task automatic send_code(input logic [7:0] raw);
      int gap;
      req_tdata  <= raw;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      gap = (sent % 100 < 20) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = (taken % 90 < 20) ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         taken++;
      end
   end

   initial begin
      #5_000_000;
      $display("scancode_set1_to_ascii_tb: errors");
      $finish;
   end

   initial begin
      scs1a_pkg::code_type key;
      bit       paused;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (OpeningCodes[i]) begin
         send_code(OpeningCodes[i]);
      end
      while (sent < 1325) begin
         case ($urandom_range(0, 9))
            0, 1: send_code({1'b0, pick_shift()});
            2: send_code({1'b1, pick_shift()});
            3, 4, 5, 6, 7: begin
               key = pick_key();
               send_code({1'b0, key});
               if ($urandom_range(0, 1)) begin
                  send_code({1'b1, key});
               end
            end
            8: send_code(8'($urandom_range(0, 255)));
            default: begin
               send_code($urandom_range(0, 1) ? 8'hE0 : 8'hE1);
               send_code(8'($urandom_range(0, 255)));
            end
         endcase
         if (!paused && sent >= 700) begin
            drain_results();
            paused = 1'b1;
         end
      end
      drain_results();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("scancode_set1_to_ascii_tb: clean");
      end else begin
         $display("scancode_set1_to_ascii_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/scs1a_pkg.sv
hdl/scancode_set1_to_ascii.sv
dv/scancode_set1_to_ascii_check.sv
dv/scancode_set1_to_ascii_tb.sv
